@@ hw/rtl/sdspi_pkg.sv @@
// Package for the SD card SPI-mode host sequencer.
// Holds phase and code enums, constants and the result record type.
// No dependencies.
package sdspi_pkg;

    localparam int SECTOR_BYTES_DEF = 512;

    typedef enum logic [4:0] {
        PH_IDLE, PH_WAKE, PH_PRE, PH_FRAME, PH_DUMMY, PH_POLL, PH_TOKEN, PH_RDATA,
        PH_RCRC, PH_GAP, PH_WTOKEN, PH_WDATA, PH_WNEED, PH_WCRC, PH_WRESP, PH_BUSY
    } phase_t;

    typedef enum logic [1:0] {
        OP_INIT0 = 2'd0,
        OP_READ  = 2'd1,
        OP_WRITE = 2'd2,
        OP_INIT1 = 2'd3
    } op_t;

    typedef enum logic [2:0] {
        MODE_INIT  = 3'd0,
        MODE_READ  = 3'd1,
        MODE_WRITE = 3'd2,
        MODE_CARD  = 3'd3,
        MODE_HOST  = 3'd4
    } mode_t;

    localparam logic [1:0] KIND_XCHG = 2'd0;
    localparam logic [1:0] KIND_READ = 2'd1;
    localparam logic [1:0] KIND_NEED = 2'd2;
    localparam logic [1:0] KIND_DONE = 2'd3;

    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_RESET     = 3'd1;
    localparam logic [2:0] ST_INIT      = 3'd2;
    localparam logic [2:0] ST_CMD       = 3'd3;
    localparam logic [2:0] ST_TOKEN     = 3'd4;
    localparam logic [2:0] ST_REJECT    = 3'd5;
    localparam logic [2:0] ST_BUSY      = 3'd6;
    localparam logic [2:0] ST_WINDOW    = 3'd7;

    localparam logic [2:0] REG_RETRY = 3'd0;
    localparam logic [2:0] REG_POLL  = 3'd1;
    localparam logic [2:0] REG_GAP   = 3'd2;
    localparam logic [2:0] REG_WAKE  = 3'd3;
    localparam logic [2:0] REG_ARG   = 3'd4;

    localparam logic [7:0] CMD_BASE   = 8'h40;
    localparam logic [7:0] CRC_CMD0   = 8'h95;
    localparam logic [7:0] TOKEN_DATA = 8'hfe;
    localparam logic [4:0] RESP_OK    = 5'h05;
    localparam logic [7:0] IDLE_BYTE  = 8'hff;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] tx_byte;
        logic       cs_active;
        logic       fast_clock;
        logic [7:0] read_byte;
        logic [2:0] status;
    } res_t;

    typedef struct packed {
        logic [7:0]  retry_limit;
        logic [7:0]  poll_limit;
        logic [7:0]  write_gap_bytes;
        logic [7:0]  wake_bytes;
        logic [31:0] op_cond_argument;
    } cfg_t;

endpackage

@@ hw/rtl/sd_spi_host_sequencer.sv @@
// Top level of the SD card SPI-mode host sequencer.
// Instantiates sdspi_regs, sdspi_core and sdspi_outq; depends on sdspi_pkg.
//
// The input channel (in_valid, in_stall) carries one command or one byte event per
// transfer: start init, read or write, a card byte for the last exchange, or a host
// write byte. The output channel (out_valid, out_stall) carries the results of
// each input transfer, zero to two records, the final one marked by last.
// An input transfer is taken whenever the result queue is empty or is being drained
// of its final record in the same cycle, so a new input can follow every cycle
// while the receiver keeps up. Results appear in the cycle after the input transfer
// and then one per cycle; an input that yields two records holds off the next input
// transfer until its second record is being drained. When the receiver stalls, the
// queue holds its records and in_stall is raised. Reset puts the sequencer in idle
// at slow clock and loads the register defaults. Configuration must be written by
// the user via the APB-style port while the block is idle, which is not enforced.
module sd_spi_host_sequencer #(
    parameter int SECTOR_BYTES = sdspi_pkg::SECTOR_BYTES_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [2:0]  mode,
    input  logic [22:0] sector,
    input  logic [9:0]  first_offset,
    input  logic [9:0]  byte_count,
    input  logic [7:0]  card_byte,
    input  logic [7:0]  write_byte,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [1:0]  kind,
    output logic [7:0]  tx_byte,
    output logic        cs_active,
    output logic        fast_clock,
    output logic [7:0]  read_byte,
    output logic [2:0]  status,
    output logic        last
);
    sdspi_pkg::cfg_t cfg;
    sdspi_pkg::res_t r0, r1, r2, head;
    logic [1:0]      res_n;
    logic            step, empty_next;

    assign pready = 1'b1;
    assign in_stall = !empty_next;
    assign step = in_valid && empty_next;

    sdspi_regs u_regs (
        .clk(clk), .rst_n(rst_n), .psel(psel), .penable(penable), .pwrite(pwrite),
        .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .cfg(cfg)
    );

    sdspi_core #(.SECTOR_BYTES(SECTOR_BYTES)) u_core (
        .clk(clk), .rst_n(rst_n), .step(step), .mode(mode), .sector(sector),
        .first_offset(first_offset), .byte_count(byte_count), .card_byte(card_byte),
        .write_byte(write_byte), .cfg(cfg), .res_n(res_n),
        .res0(r0), .res1(r1), .res2(r2)
    );

    sdspi_outq u_outq (
        .clk(clk), .rst_n(rst_n), .load(step && res_n != 2'd0),
        .load_n(res_n), .load0(r0), .load1(r1), .load2(r2), .stall(out_stall),
        .valid(out_valid), .empty_next(empty_next), .head(head), .last(last)
    );

    assign kind       = head.kind;
    assign tx_byte    = head.tx_byte;
    assign cs_active  = head.cs_active;
    assign fast_clock = head.fast_clock;
    assign read_byte  = head.read_byte;
    assign status     = head.status;
endmodule

@@ hw/rtl/sdspi_regs.sv @@
// Configuration register file for the SD SPI host sequencer.
// APB-style write and read port; depends on sdspi_pkg.
module sdspi_regs (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [4:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output sdspi_pkg::cfg_t     cfg
);
    sdspi_pkg::cfg_t cfg_reg;
    logic [2:0]      idx;

    assign idx = paddr[4:2];
    assign cfg = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.retry_limit      <= 8'd200;
            cfg_reg.poll_limit       <= 8'd100;
            cfg_reg.write_gap_bytes  <= 8'd100;
            cfg_reg.wake_bytes       <= 8'd15;
            cfg_reg.op_cond_argument <= 32'h00ffc000;
        end
        else if (psel && penable && pwrite)
        begin
            unique case (idx)
                sdspi_pkg::REG_RETRY: cfg_reg.retry_limit      <= pwdata[7:0];
                sdspi_pkg::REG_POLL:  cfg_reg.poll_limit       <= pwdata[7:0];
                sdspi_pkg::REG_GAP:   cfg_reg.write_gap_bytes  <= pwdata[7:0];
                sdspi_pkg::REG_WAKE:  cfg_reg.wake_bytes       <= pwdata[7:0];
                sdspi_pkg::REG_ARG:   cfg_reg.op_cond_argument <= pwdata;
                default: ;
            endcase
        end
    end

    always_comb
    begin
        unique case (idx)
            sdspi_pkg::REG_RETRY: prdata = {24'd0, cfg_reg.retry_limit};
            sdspi_pkg::REG_POLL:  prdata = {24'd0, cfg_reg.poll_limit};
            sdspi_pkg::REG_GAP:   prdata = {24'd0, cfg_reg.write_gap_bytes};
            sdspi_pkg::REG_WAKE:  prdata = {24'd0, cfg_reg.wake_bytes};
            sdspi_pkg::REG_ARG:   prdata = cfg_reg.op_cond_argument;
            default:              prdata = 32'd0;
        endcase
    end
endmodule

@@ hw/rtl/sdspi_core.sv @@
// Sequencer core: state registers and next-state logic for one input transfer.
// Produces up to two result records per transfer; depends on sdspi_pkg.
module sdspi_core #(
    parameter int SECTOR_BYTES = sdspi_pkg::SECTOR_BYTES_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               step,
    input  logic [2:0]         mode,
    input  logic [22:0]        sector,
    input  logic [9:0]         first_offset,
    input  logic [9:0]         byte_count,
    input  logic [7:0]         card_byte,
    input  logic [7:0]         write_byte,
    input  sdspi_pkg::cfg_t    cfg,
    output logic [1:0]         res_n,
    output sdspi_pkg::res_t    res0,
    output sdspi_pkg::res_t    res1,
    output sdspi_pkg::res_t    res2
);
    localparam int IW = $clog2(SECTOR_BYTES + 1);
    localparam logic [IW-1:0] SEC = IW'(SECTOR_BYTES);

    sdspi_pkg::phase_t phase_reg, phase_next;
    sdspi_pkg::op_t    op_reg, op_next;
    logic [7:0]        retry_reg, retry_next, poll_reg, poll_next;
    logic [IW-1:0]     idx_reg, idx_next;
    logic [22:0]       sector_reg, sector_next;
    logic [IW-1:0]     off_reg, off_next, cnt_reg, cnt_next;
    logic              fast_reg, fast_next;

    logic [7:0] rlim, plim;
    logic [1:0] n;
    sdspi_pkg::res_t r [3];

    assign rlim = (cfg.retry_limit == 8'd0) ? 8'd1 : cfg.retry_limit;
    assign plim = (cfg.poll_limit == 8'd0) ? 8'd1 : cfg.poll_limit;

    function automatic logic [7:0] frame_byte(input sdspi_pkg::op_t op, input logic [2:0] i,
                                              input logic [22:0] sec, input logic [31:0] oarg);
        logic [7:0]  cmd;
        logic [31:0] arg;
        begin
            if (op == sdspi_pkg::OP_INIT0)
            begin
                cmd = 8'd0;
                arg = 32'd0;
            end
            else if (op == sdspi_pkg::OP_INIT1)
            begin
                cmd = 8'd1;
                arg = oarg;
            end
            else
            begin
                cmd = (op == sdspi_pkg::OP_READ) ? 8'd17 : 8'd24;
                arg = {sec, 9'd0};
            end
            unique case (i)
                3'd0:    frame_byte = sdspi_pkg::CMD_BASE | cmd;
                3'd1:    frame_byte = arg[31:24];
                3'd2:    frame_byte = arg[23:16];
                3'd3:    frame_byte = arg[15:8];
                3'd4:    frame_byte = arg[7:0];
                default: frame_byte = (op == sdspi_pkg::OP_INIT0) ? sdspi_pkg::CRC_CMD0
                                                                   : sdspi_pkg::IDLE_BYTE;
            endcase
        end
    endfunction

    always_comb
    begin
        logic [IW-1:0] bi;
        logic          inwin;
        logic [7:0]    rc;
        logic [7:0]    pc;
        logic [7:0]    expect_b;
        phase_next  = phase_reg;
        op_next     = op_reg;
        retry_next  = retry_reg;
        poll_next   = poll_reg;
        idx_next    = idx_reg;
        sector_next = sector_reg;
        off_next    = off_reg;
        cnt_next    = cnt_reg;
        fast_next   = fast_reg;
        n = 2'd0;
        bi = '0;
        inwin = 1'b0;
        rc = 8'd0;
        pc = 8'd0;
        expect_b = 8'd0;
        for (int k = 0; k < 3; k++)
            r[k] = '0;

        if (step)
        begin
            if (mode == sdspi_pkg::MODE_INIT || mode == sdspi_pkg::MODE_READ
                || mode == sdspi_pkg::MODE_WRITE)
            begin
                if (phase_reg == sdspi_pkg::PH_IDLE)
                begin
                    retry_next = 8'd0;
                    idx_next = '0;
                    if (mode == sdspi_pkg::MODE_INIT)
                    begin
                        op_next = sdspi_pkg::OP_INIT0;
                        fast_next = 1'b0;
                        phase_next = (cfg.wake_bytes != 8'd0) ? sdspi_pkg::PH_WAKE
                                                              : sdspi_pkg::PH_PRE;
                        r[0].kind = sdspi_pkg::KIND_XCHG;
                        r[0].tx_byte = sdspi_pkg::IDLE_BYTE;
                        n = 2'd1;
                    end
                    else
                    begin
                        op_next = sdspi_pkg::op_t'(mode[1:0]);
                        sector_next = sector;
                        off_next = IW'(first_offset);
                        cnt_next = IW'(byte_count);
                        n = 2'd1;
                        if ({1'b0, first_offset} + {1'b0, byte_count} > 11'(SECTOR_BYTES))
                        begin
                            phase_next = sdspi_pkg::PH_IDLE;
                            r[0].kind = sdspi_pkg::KIND_DONE;
                            r[0].status = sdspi_pkg::ST_WINDOW;
                        end
                        else
                        begin
                            phase_next = sdspi_pkg::PH_PRE;
                            r[0].kind = sdspi_pkg::KIND_XCHG;
                            r[0].tx_byte = sdspi_pkg::IDLE_BYTE;
                        end
                    end
                end
            end
            else if (mode == sdspi_pkg::MODE_HOST)
            begin
                if (phase_reg == sdspi_pkg::PH_WNEED)
                begin
                    phase_next = sdspi_pkg::PH_WDATA;
                    r[0].kind = sdspi_pkg::KIND_XCHG;
                    r[0].tx_byte = write_byte;
                    r[0].cs_active = 1'b1;
                    n = 2'd1;
                end
            end
            else if (mode == sdspi_pkg::MODE_CARD)
            begin
                n = 2'd1;
                r[0].kind = sdspi_pkg::KIND_XCHG;
                r[0].tx_byte = sdspi_pkg::IDLE_BYTE;
                r[0].cs_active = 1'b1;
                unique case (phase_reg)
                    sdspi_pkg::PH_WAKE:
                    begin
                        idx_next = idx_reg + 1'b1;
                        r[0].cs_active = 1'b0;
                        if (idx_next >= IW'(cfg.wake_bytes))
                            phase_next = sdspi_pkg::PH_PRE;
                    end
                    sdspi_pkg::PH_PRE:
                    begin
                        phase_next = sdspi_pkg::PH_FRAME;
                        idx_next = '0;
                        r[0].tx_byte = frame_byte(op_reg, 3'd0, sector_reg,
                                                  cfg.op_cond_argument);
                    end
                    sdspi_pkg::PH_FRAME:
                    begin
                        idx_next = idx_reg + 1'b1;
                        if (idx_next >= IW'(6))
                            phase_next = sdspi_pkg::PH_DUMMY;
                        else
                            r[0].tx_byte = frame_byte(op_reg, idx_next[2:0], sector_reg,
                                                      cfg.op_cond_argument);
                    end
                    sdspi_pkg::PH_DUMMY:
                    begin
                        phase_next = sdspi_pkg::PH_POLL;
                        poll_next = 8'd0;
                    end
                    sdspi_pkg::PH_POLL:
                    begin
                        pc = poll_reg + 8'd1;
                        poll_next = pc;
                        if (card_byte != 8'hff || pc >= plim)
                        begin
                            expect_b = (op_reg == sdspi_pkg::OP_INIT0) ? 8'h01 : 8'h00;
                            if (card_byte == expect_b)
                            begin
                                retry_next = 8'd0;
                                unique case (op_reg)
                                    sdspi_pkg::OP_INIT0:
                                    begin
                                        op_next = sdspi_pkg::OP_INIT1;
                                        phase_next = sdspi_pkg::PH_PRE;
                                        r[0].cs_active = 1'b0;
                                    end
                                    sdspi_pkg::OP_INIT1:
                                    begin
                                        fast_next = 1'b1;
                                        phase_next = sdspi_pkg::PH_IDLE;
                                        r[0] = '0;
                                        r[0].kind = sdspi_pkg::KIND_DONE;
                                    end
                                    sdspi_pkg::OP_READ:
                                        phase_next = sdspi_pkg::PH_TOKEN;
                                    default:
                                    begin
                                        idx_next = '0;
                                        if (cfg.write_gap_bytes == 8'd0)
                                        begin
                                            phase_next = sdspi_pkg::PH_WTOKEN;
                                            r[0].tx_byte = sdspi_pkg::TOKEN_DATA;
                                        end
                                        else
                                            phase_next = sdspi_pkg::PH_GAP;
                                    end
                                endcase
                            end
                            else
                            begin
                                rc = retry_reg + 8'd1;
                                retry_next = rc;
                                if (rc >= rlim)
                                begin
                                    phase_next = sdspi_pkg::PH_IDLE;
                                    r[0] = '0;
                                    r[0].kind = sdspi_pkg::KIND_DONE;
                                    r[0].status = (op_reg == sdspi_pkg::OP_INIT0)
                                        ? sdspi_pkg::ST_RESET
                                        : ((op_reg == sdspi_pkg::OP_INIT1)
                                           ? sdspi_pkg::ST_INIT : sdspi_pkg::ST_CMD);
                                end
                                else
                                begin
                                    phase_next = sdspi_pkg::PH_PRE;
                                    r[0].cs_active = 1'b0;
                                end
                            end
                        end
                    end
                    sdspi_pkg::PH_TOKEN:
                    begin
                        rc = retry_reg + 8'd1;
                        retry_next = rc;
                        if (card_byte == sdspi_pkg::TOKEN_DATA)
                        begin
                            phase_next = sdspi_pkg::PH_RDATA;
                            idx_next = '0;
                        end
                        else if (rc >= rlim)
                        begin
                            phase_next = sdspi_pkg::PH_IDLE;
                            r[0] = '0;
                            r[0].kind = sdspi_pkg::KIND_DONE;
                            r[0].status = sdspi_pkg::ST_TOKEN;
                        end
                    end
                    sdspi_pkg::PH_RDATA:
                    begin
                        inwin = ({1'b0, idx_reg} >= {1'b0, off_reg})
                                && ({1'b0, idx_reg} < ({1'b0, off_reg} + {1'b0, cnt_reg}));
                        bi = idx_reg + 1'b1;
                        idx_next = bi;
                        if (bi >= SEC)
                        begin
                            phase_next = sdspi_pkg::PH_RCRC;
                            idx_next = '0;
                        end
                        if (inwin)
                        begin
                            r[1] = r[0];
                            r[0] = '0;
                            r[0].kind = sdspi_pkg::KIND_READ;
                            r[0].read_byte = card_byte;
                            n = 2'd2;
                        end
                    end
                    sdspi_pkg::PH_RCRC:
                    begin
                        idx_next = idx_reg + 1'b1;
                        if (idx_next >= IW'(2))
                        begin
                            phase_next = sdspi_pkg::PH_IDLE;
                            r[0] = '0;
                            r[0].kind = sdspi_pkg::KIND_DONE;
                        end
                    end
                    sdspi_pkg::PH_GAP:
                    begin
                        idx_next = idx_reg + 1'b1;
                        if (idx_next >= IW'(cfg.write_gap_bytes))
                        begin
                            phase_next = sdspi_pkg::PH_WTOKEN;
                            r[0].tx_byte = sdspi_pkg::TOKEN_DATA;
                        end
                    end
                    sdspi_pkg::PH_WTOKEN, sdspi_pkg::PH_WDATA:
                    begin
                        bi = (phase_reg == sdspi_pkg::PH_WTOKEN) ? '0 : idx_reg + 1'b1;
                        idx_next = bi;
                        inwin = ({1'b0, bi} >= {1'b0, off_reg})
                                && ({1'b0, bi} < ({1'b0, off_reg} + {1'b0, cnt_reg}));
                        if (bi >= SEC)
                        begin
                            phase_next = sdspi_pkg::PH_WCRC;
                            idx_next = '0;
                        end
                        else if (inwin)
                        begin
                            phase_next = sdspi_pkg::PH_WNEED;
                            r[0] = '0;
                            r[0].kind = sdspi_pkg::KIND_NEED;
                        end
                        else
                        begin
                            phase_next = sdspi_pkg::PH_WDATA;
                            r[0].tx_byte = 8'h00;
                        end
                    end
                    sdspi_pkg::PH_WCRC:
                    begin
                        idx_next = idx_reg + 1'b1;
                        if (idx_next >= IW'(2))
                            phase_next = sdspi_pkg::PH_WRESP;
                    end
                    sdspi_pkg::PH_WRESP:
                    begin
                        if (card_byte[4:0] == sdspi_pkg::RESP_OK)
                        begin
                            phase_next = sdspi_pkg::PH_BUSY;
                            retry_next = 8'd0;
                        end
                        else
                        begin
                            phase_next = sdspi_pkg::PH_IDLE;
                            r[0] = '0;
                            r[0].kind = sdspi_pkg::KIND_DONE;
                            r[0].status = sdspi_pkg::ST_REJECT;
                        end
                    end
                    sdspi_pkg::PH_BUSY:
                    begin
                        rc = retry_reg + 8'd1;
                        retry_next = rc;
                        if (card_byte == 8'hff || rc >= rlim)
                        begin
                            phase_next = sdspi_pkg::PH_IDLE;
                            r[0] = '0;
                            r[0].kind = sdspi_pkg::KIND_DONE;
                            r[0].status = (card_byte == 8'hff) ? sdspi_pkg::ST_OK
                                                               : sdspi_pkg::ST_BUSY;
                        end
                    end
                    default:
                    begin
                        n = 2'd0;
                        r[0] = '0;
                    end
                endcase
            end
        end
        for (int k = 0; k < 3; k++)
            r[k].fast_clock = fast_next;
    end

    assign res_n = n;
    assign res0 = r[0];
    assign res1 = r[1];
    assign res2 = r[2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= sdspi_pkg::PH_IDLE;
            op_reg     <= sdspi_pkg::OP_INIT0;
            retry_reg  <= 8'd0;
            poll_reg   <= 8'd0;
            idx_reg    <= '0;
            sector_reg <= 23'd0;
            off_reg    <= '0;
            cnt_reg    <= '0;
            fast_reg   <= 1'b0;
        end
        else
        begin
            phase_reg  <= phase_next;
            op_reg     <= op_next;
            retry_reg  <= retry_next;
            poll_reg   <= poll_next;
            idx_reg    <= idx_next;
            sector_reg <= sector_next;
            off_reg    <= off_next;
            cnt_reg    <= cnt_next;
            fast_reg   <= fast_next;
        end
    end
endmodule

@@ hw/rtl/sdspi_outq.sv @@
// Result queue: holds the records of one transfer and hands them out in order.
// Depends on sdspi_pkg.
module sdspi_outq (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            load,
    input  logic [1:0]      load_n,
    input  sdspi_pkg::res_t load0,
    input  sdspi_pkg::res_t load1,
    input  sdspi_pkg::res_t load2,
    input  logic            stall,
    output logic            valid,
    output logic            empty_next,
    output sdspi_pkg::res_t head,
    output logic            last
);
    sdspi_pkg::res_t q_reg [3];
    logic [1:0]      cnt_reg, cnt_next;
    logic            pop;

    assign valid = (cnt_reg != 2'd0);
    assign pop = valid && !stall;
    assign head = q_reg[0];
    assign last = (cnt_reg == 2'd1);
    assign empty_next = (cnt_reg == 2'd0) || (pop && cnt_reg == 2'd1);

    always_comb
    begin
        cnt_next = cnt_reg;
        if (pop)
            cnt_next = cnt_reg - 2'd1;
        if (load)
            cnt_next = load_n;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cnt_reg <= 2'd0;
        else
            cnt_reg <= cnt_next;
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            q_reg[0] <= load0;
            q_reg[1] <= load1;
            q_reg[2] <= load2;
        end
        else if (pop)
        begin
            q_reg[0] <= q_reg[1];
            q_reg[1] <= q_reg[2];
        end
    end
endmodule

@@ hw/rtl/sdspi_checker.sv @@
// Port-level checker for the SD SPI host sequencer, bound to the top level.
// Depends on sdspi_pkg and the top-level ports.
module sdspi_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       in_valid,
    input logic       in_stall,
    input logic       out_valid,
    input logic       out_stall,
    input logic [1:0] kind,
    input logic [7:0] tx_byte,
    input logic [2:0] status,
    input logic       last
);
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(kind) && $stable(tx_byte))
        else $error("stalled result changed");

    a_stall_busy: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |-> in_stall)
        else $error("input taken while a result is stalled");

    a_status: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && kind != sdspi_pkg::KIND_DONE |-> status == sdspi_pkg::ST_OK)
        else $error("status set on a non-done result");

    a_done_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && kind == sdspi_pkg::KIND_DONE |-> last)
        else $error("done result not final");
endmodule

bind sd_spi_host_sequencer sdspi_checker u_checker (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
    .out_valid(out_valid), .out_stall(out_stall), .kind(kind), .tx_byte(tx_byte),
    .status(status), .last(last)
);
